>>> hdl/scrolling_segment_text_display_macros.svh
// Assertion macros shared by the display checker.
`ifndef SCROLLING_SEGMENT_TEXT_DISPLAY_MACROS_SVH
`define SCROLLING_SEGMENT_TEXT_DISPLAY_MACROS_SVH

// Same-cycle implication, off during reset. Expects clk and rst in scope.
`define SSD_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, off during reset.
`define SSD_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Next-cycle implication that also checks across reset.
`define SSD_ASSERT_RST(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/ssd_pkg.sv
// Shared types, constants and character/segment tables for the text display.
`timescale 1ns / 1ps

package ssd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_ADDR,
    ST_EMIT
  } state_t;

  localparam int REG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CHAR_W    = 8;
  localparam int CODE_W    = 6;
  localparam int SEG_W     = 16;
  localparam int TICK_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY   = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [REG_W-1:0]  SCROLL_PERIOD_RST = 8'd3;
  localparam logic [REG_W-1:0]  START_DELAY_RST   = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] FIRST_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] LAST_CHAR  = 8'h5F;
  localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

  // Any code at or above the table size shows as blank.
  localparam logic [CODE_W-1:0] BLANK_CODE = 6'h3F;

  function automatic logic [CODE_W-1:0] char_to_code(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    f = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      f = c & ~CASE_BIT;
    end
    if (f >= FIRST_CHAR && f <= LAST_CHAR) begin
      return CODE_W'(f - FIRST_CHAR);
    end
    return BLANK_CODE;
  endfunction

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] s;
    unique case (code)
      6'd0:    s = 16'hEAA8;
      6'd1:    s = 16'h2A80;
      6'd2:    s = 16'h4000;
      6'd3:    s = 16'h0A00;
      6'd4:    s = 16'h0A51;
      6'd5:    s = 16'h4008;
      6'd6:    s = 16'h5559;
      6'd7:    s = 16'h0118;
      6'd8:    s = 16'h1E11;
      6'd9:    s = 16'h1B11;
      6'd10:   s = 16'h0B50;
      6'd11:   s = 16'h1B41;
      6'd12:   s = 16'h1F41;
      6'd13:   s = 16'h0111;
      6'd14:   s = 16'h1F51;
      6'd15:   s = 16'h1B51;
      6'd18:   s = 16'h8008;
      6'd19:   s = 16'h1A00;
      6'd20:   s = 16'h4020;
      6'd23:   s = 16'h0F51;
      6'd24:   s = 16'h3991;
      6'd25:   s = 16'h1441;
      6'd26:   s = 16'h3191;
      6'd27:   s = 16'h1E41;
      6'd28:   s = 16'h0E41;
      6'd29:   s = 16'h1D41;
      6'd30:   s = 16'h0F50;
      6'd31:   s = 16'h2080;
      6'd32:   s = 16'h1510;
      6'd33:   s = 16'h8648;
      6'd34:   s = 16'h1440;
      6'd35:   s = 16'h0578;
      6'd36:   s = 16'h8570;
      6'd37:   s = 16'h1551;
      6'd38:   s = 16'h0E51;
      6'd39:   s = 16'h9551;
      6'd40:   s = 16'h8E51;
      6'd41:   s = 16'h9021;
      6'd42:   s = 16'h2081;
      6'd43:   s = 16'h1550;
      6'd44:   s = 16'h4448;
      6'd45:   s = 16'hC550;
      6'd46:   s = 16'hC028;
      6'd47:   s = 16'h2028;
      6'd48:   s = 16'h5009;
      6'd49:   s = 16'h1441;
      6'd50:   s = 16'h8020;
      6'd51:   s = 16'h1111;
      6'd53:   s = 16'h1000;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/ssd_addr_unit.sv
// Shared add / compare / wrap unit for store addressing and window checks.
`timescale 1ns / 1ps

module ssd_addr_unit #(
  parameter int W = 8
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] modulus,
  input  logic         wrap,
  output logic [W-1:0] sum,
  output logic [W-1:0] wrapped
);

  assign sum = a + b;

  // Caller keeps sum below twice the modulus, so one subtract suffices.
  always_comb begin
    if (wrap && (modulus != '0) && (sum >= modulus)) begin
      wrapped = sum - modulus;
    end else begin
      wrapped = sum;
    end
  end

endmodule

>>> hdl/scrolling_segment_text_display.sv
// Top level of the scrolling segment text display controller.
//
// Input stream (s_axis_*): one item per handshake. s_axis_tuser is the
// function (0 = load one character, 1 = display frame tick), s_axis_tdata
// the character byte, s_axis_tlast marks the final character of a string.
// A NUL character or tlast ends the string; the block then writes DIGITS+1
// blank codes into the text store, one per cycle; the input is held until
// the last blank code is written.
// Output stream (m_axis_*): one segment word per digit of a redraw, digit
// 0 first, tlast on the final digit. A tick that triggers a redraw holds
// the input while each digit passes an address state (shared add/wrap
// unit, registered store read) and an emit state (segment lookup into the
// output register). Ticks that cause no redraw do not hold the input.
// The result sits in an output register, so a stalled receiver only
// holds the sequencer when the next digit is ready; once the final digit
// is registered the input is open again.
// Config port: cfg_we writes cfg_wdata into register cfg_index
// (0 scroll period, 1 start delay). Write only while idle.
// Reset (rst, synchronous) clears all control state and restores the
// register defaults; the text store holds no reset and is always written
// before it is read.
`timescale 1ns / 1ps

module scrolling_segment_text_display #(
  parameter int TEXT_CAPACITY = 32,
  parameter int DIGITS        = 6,
  localparam int DIGIT_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1,
  localparam int OUT_W        = DIGIT_W + ssd_pkg::SEG_W + 1,
  localparam int TDATA_W      = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssd_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ssd_pkg::CHAR_W-1:0]    s_axis_tdata,  // [7:0] char_code
  input  logic                          s_axis_tuser,  // [0] func
  input  logic                          s_axis_tlast,  // last_char
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [TDATA_W-1:0]            m_axis_tdata,  // digit, segments, scroll_done, zero pad
  output logic                          m_axis_tlast   // last
);

  import ssd_pkg::*;

  localparam int DEPTH  = TEXT_CAPACITY + DIGITS + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = POS_W + 1;
  localparam int CNT_W  = $clog2(TEXT_CAPACITY + 1);
  localparam int FILL_W = $clog2(DIGITS + 1);

  // Configuration registers
  logic [REG_W-1:0] scroll_period;
  logic [REG_W-1:0] start_delay;

  // Control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   load_count;
  logic               loading_active;
  logic               discarding;
  logic [POS_W-1:0]   window_start;
  logic [POS_W-1:0]   text_end;
  logic [TICK_W-1:0]  tick_counter;
  logic               scroll_enabled;
  logic               done_flag;
  logic               redraw_pending;
  logic [FILL_W-1:0]  fill_n;
  logic [DIGIT_W-1:0] dig;

  // Text store: one write, one registered read per cycle
  logic [CODE_W-1:0] text_store [DEPTH];
  logic [CODE_W-1:0] rd_code;

  // Output register
  logic [DIGIT_W-1:0] out_digit;
  logic [SEG_W-1:0]   out_seg;
  logic               out_done;
  logic               out_last;

  // Shared unit hookup
  logic [SUM_W-1:0] au_a, au_b, au_sum, au_wrapped;
  logic             au_wrap;

  // Decoded item and sequencer strobes
  logic               s_accept;
  logic               is_load, is_tick;
  logic               c_nonzero, str_end;
  logic [CNT_W-1:0]   lc_eff, lc_new;
  logic               disc_eff, disc_new, store_ok;
  logic               pend_next;
  logic [TICK_W-1:0]  tick_next;
  logic               out_free;
  logic               fill_last, dig_last;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CODE_W-1:0]  mem_wdata;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_load       = s_accept && (s_axis_tuser == FUNC_LOAD);
  assign is_tick       = s_accept && (s_axis_tuser == FUNC_TICK) && !loading_active;
  assign c_nonzero     = (s_axis_tdata != CHAR_NUL);
  assign str_end       = !c_nonzero || s_axis_tlast;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fill_last     = (fill_n == FILL_W'(DIGITS));
  assign dig_last      = (dig == DIGIT_W'(DIGITS - 1));

  // A load item that starts a new string counts from zero.
  assign lc_eff   = loading_active ? load_count : '0;
  assign disc_eff = loading_active && discarding;
  assign store_ok = c_nonzero && !disc_eff && (lc_eff < CNT_W'(TEXT_CAPACITY));
  assign lc_new   = lc_eff + CNT_W'(store_ok);
  assign disc_new = disc_eff || (c_nonzero && (lc_new >= CNT_W'(TEXT_CAPACITY)));

  // Scroll timer step for a tick
  always_comb begin
    pend_next = redraw_pending;
    tick_next = tick_counter;
    if (scroll_enabled) begin
      if (tick_counter == '0) begin
        pend_next = 1'b1;
        tick_next = TICK_W'(scroll_period);
      end else begin
        tick_next = tick_counter - TICK_W'(1);
      end
    end
  end

  // Shared unit operand select: idle checks window end, fill walks the
  // blank tail, address step walks the window with wrap.
  always_comb begin
    au_a    = SUM_W'(window_start);
    au_b    = SUM_W'(DIGITS);
    au_wrap = 1'b0;
    unique case (state)
      ST_FILL: begin
        au_a = SUM_W'(load_count);
        au_b = SUM_W'(fill_n);
      end
      ST_ADDR: begin
        au_b    = SUM_W'(dig);
        au_wrap = 1'b1;
      end
      ST_IDLE, ST_EMIT: begin
      end
    endcase
  end

  ssd_addr_unit #(
    .W (SUM_W)
  ) u_addr_unit (
    .a       (au_a),
    .b       (au_b),
    .modulus (SUM_W'(text_end)),
    .wrap    (au_wrap),
    .sum     (au_sum),
    .wrapped (au_wrapped)
  );

  // Store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(lc_eff);
    mem_wdata = char_to_code(s_axis_tdata);
    if (state == ST_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = au_sum[ADDR_W-1:0];
      mem_wdata = BLANK_CODE;
    end else if (is_load && store_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_store[mem_waddr] <= mem_wdata;
    end
    if (state == ST_ADDR) begin
      rd_code <= text_store[au_wrapped[ADDR_W-1:0]];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_load && str_end) begin
          state_next = ST_FILL;
        end else if (is_tick && pend_next) begin
          state_next = ST_ADDR;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ADDR: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = dig_last ? ST_IDLE : ST_ADDR;
        end
      end
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_period <= SCROLL_PERIOD_RST;
      start_delay   <= START_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCROLL_PERIOD: scroll_period <= cfg_wdata;
        REG_START_DELAY:   start_delay   <= cfg_wdata;
      endcase
    end
  end

  // Loading, scrolling and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count     <= '0;
      loading_active <= 1'b0;
      discarding     <= 1'b0;
      window_start   <= '0;
      text_end       <= '0;
      tick_counter   <= '0;
      scroll_enabled <= 1'b0;
      done_flag      <= 1'b0;
      redraw_pending <= 1'b0;
      fill_n         <= '0;
      dig            <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (is_load) begin
            loading_active <= 1'b1;
            load_count     <= lc_new;
            discarding     <= disc_new;
            fill_n         <= '0;
          end else if (is_tick) begin
            tick_counter   <= tick_next;
            redraw_pending <= pend_next;
            dig            <= '0;
            // scroll_done goes up on the redraw that shows the blank tail
            if (pend_next && (au_sum == SUM_W'(text_end))) begin
              done_flag <= 1'b1;
            end
          end
        end
        ST_FILL: begin
          if (fill_last) begin
            scroll_enabled <= (POS_W'(load_count) > POS_W'(DIGITS));
            done_flag      <= 1'b0;
            text_end       <= POS_W'(load_count) + POS_W'(DIGITS + 1);
            window_start   <= '0;
            tick_counter   <= TICK_W'(scroll_period) + TICK_W'(start_delay);
            redraw_pending <= 1'b1;
            loading_active <= 1'b0;
            discarding     <= 1'b0;
          end else begin
            fill_n <= fill_n + FILL_W'(1);
          end
        end
        ST_ADDR: begin
        end
        ST_EMIT: begin
          if (out_free) begin
            if (dig_last) begin
              redraw_pending <= 1'b0;
              // text_end is the same position as 0, so wrap lands on 1
              window_start <= (window_start == text_end) ? POS_W'(1)
                                                         : window_start + POS_W'(1);
            end else begin
              dig <= dig + DIGIT_W'(1);
            end
          end
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      out_digit <= dig;
      out_seg   <= seg_lookup(rd_code);
      out_done  <= done_flag;
      out_last  <= dig_last;
    end
  end

  assign m_axis_tdata = TDATA_W'({out_done, out_seg, out_digit});
  assign m_axis_tlast = out_last;

endmodule

>>> hdl/ssd_checker.sv
// Port-level checks for the scrolling text display, bound to the top level.
`timescale 1ns / 1ps
`include "scrolling_segment_text_display_macros.svh"

module ssd_checker #(
  parameter int DIGITS   = 6,
  localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1,
  localparam int OUT_W   = DIGIT_W + ssd_pkg::SEG_W + 1,
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  // stalled output item holds
  `SSD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

  // tlast marks exactly the final digit
  `SSD_ASSERT_IMP(a_last_digit, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[DIGIT_W-1:0] == DIGIT_W'(DIGITS - 1)), "tlast does not match final digit")

  // mid-redraw the sequencer is busy, so no input is taken
  `SSD_ASSERT_IMP(a_busy_mid_redraw, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during a redraw")

  // reset empties the output register
  `SSD_ASSERT_RST(a_reset_clear, rst, !m_axis_tvalid, "output valid after reset")

endmodule

bind scrolling_segment_text_display ssd_checker #(.DIGITS(DIGITS)) u_ssd_checker (.*);
